[design/numeric_table_text_tokenizer_macros.svh]
// Assertion macros shared by the tokenizer modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef NUMERIC_TABLE_TEXT_TOKENIZER_MACROS_SVH
`define NUMERIC_TABLE_TEXT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define NTT_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication.
`define NTT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tokenizer assertion failed");

`else

`define NTT_ASSERT_IMPLY(label, cond, prop)
`define NTT_ASSERT_NEXT(label, cond, prop)

`endif

`endif

[design/ntt_pkg.sv]
`default_nettype none

package ntt_pkg;

  // Row limit and derived counter width
  localparam int MAX_ROWS  = 256;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  // Field widths
  localparam int ROW_W    = 8;
  localparam int COL_W    = 2;
  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLCNT_W = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam logic [VALUE_W-1:0]  VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [COLCNT_W-1:0] COL_LIMIT = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NON_DIGIT = 2'd1,
    ST_FIFTH_COL = 2'd2,
    ST_ROWS_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [COL_W-1:0]   column;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

endpackage

`default_nettype wire

[design/ntt_core.sv]
`default_nettype none

`include "numeric_table_text_tokenizer_macros.svh"

module ntt_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_xfer,
  input  wire ntt_pkg::opcode_t  in_op,
  input  wire logic [7:0]        in_char,
  output logic                   res_valid,
  output ntt_pkg::result_t       res
);
  import ntt_pkg::*;

  localparam int ROW_EXT_W = (ROW_CNT_W > ROW_W) ? ROW_CNT_W : ROW_W;

  // Tokenizer state
  logic                 bc_r, bc_nxt;           // block comment open
  logic                 rest_r, rest_nxt;       // rest of line dropped
  logic                 l0_r, l0_nxt;           // pending slash that may start //
  logic                 l1v_r, l1v_nxt;         // pending pair char valid
  logic                 l1s_r, l1s_nxt;         // pending pair char is a star
  logic [VALUE_W-1:0]   word_r, word_nxt;
  logic                 wpres_r, wpres_nxt;
  logic                 wbad_r, wbad_nxt;
  logic [COLCNT_W-1:0]  col_r, col_nxt;
  logic [ROW_CNT_W-1:0] rows_r, rows_nxt;
  logic                 halted_r, halted_nxt;

  // Word accumulate: value * 10 + digit, saturated
  logic                 is_digit;
  logic [VALUE_W+3:0]   acc_sum;
  logic [VALUE_W-1:0]   acc_val;

  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign acc_sum  = {3'b000, word_r, 1'b0} + {word_r, 3'b000}
                  + (is_digit ? (VALUE_W + 4)'(in_char - CH_ZERO) : '0);
  assign acc_val  = (acc_sum > (VALUE_W + 4)'(VALUE_MAX)) ? VALUE_MAX : acc_sum[VALUE_W-1:0];

  // Result of ending the current word, from present state only
  status_t              emit_status;
  logic [ROW_EXT_W-1:0] emit_row;
  result_t              emit_res;

  always_comb begin
    priority if (wbad_r) begin
      emit_status = ST_NON_DIGIT;
    end else if (col_r == '0 && rows_r >= ROW_CNT_W'(MAX_ROWS)) begin
      emit_status = ST_ROWS_FULL;
    end else if (col_r >= COL_LIMIT) begin
      emit_status = ST_FIFTH_COL;
    end else begin
      emit_status = ST_OK;
    end
    emit_row = (col_r == '0) ? ROW_EXT_W'(rows_r) : ROW_EXT_W'(rows_r - 1'b1);
    emit_res = '0;
    emit_res.status = emit_status;
    if (emit_status == ST_OK) begin
      emit_res.row_index = emit_row[ROW_W-1:0];
      emit_res.column    = col_r[COL_W-1:0];
      emit_res.value     = word_r;
    end
  end

  // Per-transfer next state
  logic do_emit;
  logic skip;
  logic paired;
  logic is_slash;
  logic is_star;
  logic is_blank;

  assign is_slash = (in_char == CH_SLASH);
  assign is_star  = (in_char == CH_STAR);
  assign is_blank = (in_char == CH_SPACE) || (in_char == CH_TAB);

  always_comb begin
    bc_nxt     = bc_r;
    rest_nxt   = rest_r;
    l0_nxt     = l0_r;
    l1v_nxt    = l1v_r;
    l1s_nxt    = l1s_r;
    word_nxt   = word_r;
    wpres_nxt  = wpres_r;
    wbad_nxt   = wbad_r;
    col_nxt    = col_r;
    rows_nxt   = rows_r;
    halted_nxt = halted_r;
    do_emit    = 1'b0;
    skip       = 1'b0;
    paired     = 1'b0;

    if (in_xfer && !halted_r) begin
      unique case (in_op)
        OP_EOL: begin
          // A held slash can still close a comment with a held star
          if (l0_r && l1v_r && l1s_r) begin
            bc_nxt = 1'b0;
          end
          l0_nxt  = 1'b0;
          l1v_nxt = 1'b0;
          do_emit = !bc_nxt && wpres_r;
          word_nxt  = '0;
          wpres_nxt = 1'b0;
          wbad_nxt  = 1'b0;
          rest_nxt  = 1'b0;
        end
        OP_CHAR: begin
          if (!rest_r) begin
            // Line-comment detection, or block-comment close after a held star
            if (l0_r) begin
              l0_nxt = 1'b0;
              if (is_slash) begin
                rest_nxt = 1'b1;
                skip     = 1'b1;
              end else if (l1v_r && l1s_r) begin
                // held star then slash closes the block comment
                bc_nxt  = 1'b0;
                l1v_nxt = 1'b0;
              end else begin
                l1v_nxt = 1'b1;
                l1s_nxt = 1'b0;
              end
            end else if (is_slash) begin
              l0_nxt = 1'b1;
              skip   = 1'b1;
            end
            // Pairing and word building for a non-slash character
            if (!skip) begin
              if (l1v_nxt) begin
                l1v_nxt = 1'b0;
                if (!l1s_nxt && is_star) begin
                  bc_nxt = 1'b1;
                  paired = 1'b1;
                end
              end
              if (!paired) begin
                if (is_star) begin
                  l1v_nxt = 1'b1;
                  l1s_nxt = 1'b1;
                end else if (is_blank) begin
                  if (!bc_nxt && wpres_r) begin
                    do_emit   = 1'b1;
                    word_nxt  = '0;
                    wpres_nxt = 1'b0;
                    wbad_nxt  = 1'b0;
                  end
                end else if (!bc_nxt) begin
                  word_nxt  = acc_val;
                  wpres_nxt = 1'b1;
                  if (!is_digit) begin
                    wbad_nxt = 1'b1;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Counters and halt flag after an emitted word; column reset at end of line
      if (do_emit) begin
        if (emit_status != ST_OK) begin
          halted_nxt = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
          if (col_r == '0) begin
            rows_nxt = rows_r + 1'b1;
          end
        end
      end
      if (in_op == OP_EOL) begin
        col_nxt = '0;
      end
    end
  end

  assign res_valid = do_emit;
  assign res       = emit_res;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r     <= 1'b0;
      rest_r   <= 1'b0;
      l0_r     <= 1'b0;
      l1v_r    <= 1'b0;
      l1s_r    <= 1'b0;
      word_r   <= '0;
      wpres_r  <= 1'b0;
      wbad_r   <= 1'b0;
      col_r    <= '0;
      rows_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      bc_r     <= bc_nxt;
      rest_r   <= rest_nxt;
      l0_r     <= l0_nxt;
      l1v_r    <= l1v_nxt;
      l1s_r    <= l1s_nxt;
      word_r   <= word_nxt;
      wpres_r  <= wpres_nxt;
      wbad_r   <= wbad_nxt;
      col_r    <= col_nxt;
      rows_r   <= rows_nxt;
      halted_r <= halted_nxt;
    end
  end

  `NTT_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r)
  `NTT_ASSERT_IMPLY(a_no_result_when_halted, halted_r, !res_valid)
  `NTT_ASSERT_IMPLY(a_error_fields_zero, res_valid && res.status != ST_OK,
                    res.value == '0 && res.column == '0 && res.row_index == '0)
  `NTT_ASSERT_IMPLY(a_col_range, 1'b1, col_r <= COL_LIMIT)

endmodule

`default_nettype wire

[design/ntt_skid.sv]
`default_nettype none

`include "numeric_table_text_tokenizer_macros.svh"

module ntt_skid (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire ntt_pkg::result_t push_res,
  output logic              can_push,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ntt_pkg::result_t  out_res
);
  import ntt_pkg::*;

  logic    hv_r, hv_nxt;      // head holds a result
  logic    sv_r, sv_nxt;      // skid holds a result
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = hv_r && out_ready;
  assign can_push  = !sv_r;
  assign out_valid = hv_r;
  assign out_res   = head_r;

  // Two-entry queue: head drives the port, skid catches a transfer during a stall
  always_comb begin
    hv_nxt   = hv_r;
    sv_nxt   = sv_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (pop) begin
      if (sv_r) begin
        head_nxt = skid_r;
        sv_nxt   = push;
        skid_nxt = push_res;
      end else begin
        hv_nxt   = push;
        head_nxt = push_res;
      end
    end else if (push) begin
      if (hv_r) begin
        sv_nxt   = 1'b1;
        skid_nxt = push_res;
      end else begin
        hv_nxt   = 1'b1;
        head_nxt = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `NTT_ASSERT_IMPLY(a_skid_behind_head, sv_r, hv_r)
  `NTT_ASSERT_NEXT(a_skid_holds, sv_r && !out_ready, sv_r && $stable(skid_r))
  `NTT_ASSERT_IMPLY(a_no_overflow, push && sv_r, pop)

endmodule

`default_nettype wire

[design/numeric_table_text_tokenizer.sv]
// Channel | Direction | tdata                        | tuser
// --------+-----------+------------------------------+-------------------
// in_     | slave     | [7:0] char_code              | [0] opcode
// out_    | master     | [7:0] row_index, [9:8] column, | [1:0] status
//         |           | [40:10] value, [47:41] zero  |
//
// One character or end-of-line mark per cycle while in_tready is high; a
// result is queued by the transfer that ends its word and leaves from the
// head register. Rate is set by the core's per-transfer state update.
// A two-entry output queue lets input transfers continue during one stalled
// result; in_tready drops only while both entries are full.
// Synchronous active-low reset clears all control state; an error result
// halts the block until the next reset.
`default_nettype none

module numeric_table_text_tokenizer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ntt_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] char_code
  input  wire logic                                in_tuser,   // [0] opcode
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ntt_pkg::OUT_TDATA_W-1:0]          out_tdata,  // row_index, column, value
  output logic [ntt_pkg::STATUS_W-1:0]             out_tuser   // [1:0] status
);
  import ntt_pkg::*;

  logic    in_xfer;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    can_push;

  assign in_tready = can_push;
  assign in_xfer   = in_tvalid && can_push;

  ntt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_xfer   (in_xfer),
    .in_op     (opcode_t'(in_tuser)),
    .in_char   (in_tdata[CHAR_W-1:0]),
    .res_valid (res_valid),
    .res       (res)
  );

  ntt_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Output packing, first field lowest
  assign out_tdata = {(OUT_TDATA_W - ROW_W - COL_W - VALUE_W)'(0),
                      out_res.value, out_res.column, out_res.row_index};
  assign out_tuser = out_res.status;

endmodule

`default_nettype wire
